// ----- hw/rtl/apsm_pkg.sv -----
package apsm_pkg;

  localparam logic [2:0] ST_DISARMED = 3'd0;
  localparam logic [2:0] ST_EXIT     = 3'd1;
  localparam logic [2:0] ST_ARMED    = 3'd2;
  localparam logic [2:0] ST_ENTRY    = 3'd3;
  localparam logic [2:0] ST_ALARM    = 3'd4;

  localparam logic [1:0] ACT_TICK   = 2'd0;
  localparam logic [1:0] ACT_TRIP   = 2'd1;
  localparam logic [1:0] ACT_ARM    = 2'd2;
  localparam logic [1:0] ACT_DISARM = 2'd3;

  localparam logic [1:0] MODE_AWAY     = 2'd0;
  localparam logic [1:0] MODE_STAY     = 2'd1;
  localparam logic [1:0] MODE_NIGHT    = 2'd2;
  localparam logic [1:0] MODE_VACATION = 2'd3;

  localparam logic [1:0] KIND_NONE    = 2'd0;
  localparam logic [1:0] KIND_ZONE    = 2'd1;
  localparam logic [1:0] KIND_TAMPER  = 2'd2;
  localparam logic [1:0] KIND_NETWORK = 2'd3;

  localparam logic [2:0] CFG_EXIT_DELAY  = 3'd0;
  localparam logic [2:0] CFG_ENTRY_DELAY = 3'd1;
  localparam logic [2:0] CFG_NET_TIMEOUT = 3'd2;
  localparam logic [2:0] CFG_CHIME       = 3'd3;
  localparam logic [2:0] CFG_GRACE       = 3'd4;

  localparam logic [15:0] EXIT_DELAY_RESET  = 16'd600;
  localparam logic [15:0] ENTRY_DELAY_RESET = 16'd600;
  localparam logic [15:0] NET_TIMEOUT_RESET = 16'd1200;
  localparam logic [7:0]  CHIME_RESET       = 8'd20;
  localparam logic [15:0] GRACE_RESET       = 16'd100;

  localparam logic [3:0]  TAMPER_LAST = 4'd9;
  localparam logic [15:0] COUNT_MAX   = 16'hFFFF;

  typedef struct packed {
    logic [15:0] exit_delay_ticks;
    logic [15:0] entry_delay_ticks;
    logic [15:0] network_timeout_ticks;
    logic [7:0]  chime_ticks;
    logic [15:0] grace_ticks;
  } cfg_t;

  typedef struct packed {
    logic [1:0] action;
    logic [5:0] zone_index;
    logic       zone_is_camera;
    logic       zone_armed_only;
    logic       zone_fire_or_panic;
    logic       zone_is_chime;
    logic       zone_is_interior;
    logic       zone_is_perimeter;
    logic [1:0] arm_mode;
    logic       network_up;
    logic       tamper;
  } item_t;

  typedef struct packed {
    logic [2:0]  state_code;
    logic [1:0]  armed_mode;
    logic [15:0] timer_left;
    logic        siren_on;
    logic        chime_on;
    logic        alert_new;
    logic [5:0]  alert_zone;
    logic [5:0]  violation_zone;
    logic [1:0]  violation_kind;
  } result_t;

endpackage

// ----- hw/rtl/alarm_panel_arm_state_machine_core.sv -----
// alarm panel arming machine
// s_* carries one item: a tick, a zone trip, an arm request or a disarm, with
// the action code in s_tuser and the zone, mode and tick attributes in s_tdata.
// m_* returns exactly one result item per input item, in order: panel state,
// mode, delay timer, siren and chime drive, new-alert pulse and zone, and the
// latest violation.
// the cfg_* port writes the five delay/timeout registers, one per cycle; the user
// must write them only while no item is in flight, which the block does not enforce.
// an item passes through an input register, then the state update with the
// result register. one item is taken per cycle unless m_tready stalls the
// result register, a rate set by the state update loop.
// a held result does not block the input register from filling; when both are
// full and m_tready is low, s_tready drops and nothing is lost.
// reset clears the panel to disarmed, all counters, alert bits and drives,
// loads the register defaults and empties both registers.
module alarm_panel_arm_state_machine_core #(
  parameter int ZONE_COUNT = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // zone_index, zone_is_camera, zone_armed_only,
                                 // zone_fire_or_panic, zone_is_chime, zone_is_interior,
                                 // zone_is_perimeter, arm_mode, network_up, tamper
  input  logic [1:0]  s_tuser,   // action
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // state_code, armed_mode, timer_left, siren_on,
                                 // chime_on, alert_new, alert_zone, violation_zone,
                                 // violation_kind, zero fill
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  apsm_pkg::cfg_t    cfg;
  apsm_pkg::item_t   item;
  apsm_pkg::result_t result;
  apsm_pkg::result_t out_item;
  logic              in_valid;
  logic              advance;

  assign advance  = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      item.action             <= s_tuser;
      item.zone_index         <= s_tdata[5:0];
      item.zone_is_camera     <= s_tdata[6];
      item.zone_armed_only    <= s_tdata[7];
      item.zone_fire_or_panic <= s_tdata[8];
      item.zone_is_chime      <= s_tdata[9];
      item.zone_is_interior   <= s_tdata[10];
      item.zone_is_perimeter  <= s_tdata[11];
      item.arm_mode           <= s_tdata[13:12];
      item.network_up         <= s_tdata[14];
      item.tamper             <= s_tdata[15];
    end
  end

  apsm_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  apsm_core #(
    .ZONE_COUNT (ZONE_COUNT)
  ) u_core (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .item   (item),
    .step   (advance),
    .result (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_item <= result;
    end
  end

  assign m_tdata = {2'b00,
                    out_item.violation_kind,
                    out_item.violation_zone,
                    out_item.alert_zone,
                    out_item.alert_new,
                    out_item.chime_on,
                    out_item.siren_on,
                    out_item.timer_left,
                    out_item.armed_mode,
                    out_item.state_code};

  a_hold_pending: assert property (@(posedge clk) disable iff (rst)
    in_valid && m_tvalid && !m_tready |=> in_valid && m_tvalid)
    else $error("pending item dropped under stall");

  a_accept_fills: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> in_valid)
    else $error("accepted item not registered");

  a_alert_zone_idle: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !out_item.alert_new |-> out_item.alert_zone == 6'd0)
    else $error("alert zone set without alert");

endmodule

// ----- hw/rtl/apsm_cfg.sv -----
module apsm_cfg (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [2:0]        cfg_index,
  input  logic [15:0]       cfg_data,
  output apsm_pkg::cfg_t    cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.exit_delay_ticks      <= apsm_pkg::EXIT_DELAY_RESET;
      cfg.entry_delay_ticks     <= apsm_pkg::ENTRY_DELAY_RESET;
      cfg.network_timeout_ticks <= apsm_pkg::NET_TIMEOUT_RESET;
      cfg.chime_ticks           <= apsm_pkg::CHIME_RESET;
      cfg.grace_ticks           <= apsm_pkg::GRACE_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        apsm_pkg::CFG_EXIT_DELAY:  cfg.exit_delay_ticks      <= cfg_data;
        apsm_pkg::CFG_ENTRY_DELAY: cfg.entry_delay_ticks     <= cfg_data;
        apsm_pkg::CFG_NET_TIMEOUT: cfg.network_timeout_ticks <= cfg_data;
        apsm_pkg::CFG_CHIME:       cfg.chime_ticks           <= cfg_data[7:0];
        apsm_pkg::CFG_GRACE:       cfg.grace_ticks           <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

// ----- hw/rtl/apsm_core.sv -----
module apsm_core #(
  parameter int ZONE_COUNT = 64
) (
  input  logic              clk,
  input  logic              rst,
  input  apsm_pkg::cfg_t    cfg,
  input  apsm_pkg::item_t   item,
  input  logic              step,
  output apsm_pkg::result_t result
);

  localparam logic [8:0] ZONE_LIMIT = 9'(ZONE_COUNT);

  logic [2:0]            panel_state, panel_state_next;
  logic [1:0]            current_mode, current_mode_next;
  logic [15:0]           delay_count, delay_count_next;
  logic [7:0]            chime_count, chime_count_next;
  logic [15:0]           armed_tick_count, armed_tick_count_next;
  logic [15:0]           net_offline_count, net_offline_count_next;
  logic [3:0]            monitor_phase, monitor_phase_next;
  logic [ZONE_COUNT-1:0] alert_sent, alert_sent_next;
  logic [5:0]            lv_zone, lv_zone_next;
  logic [1:0]            lv_kind, lv_kind_next;
  logic                  siren_drive, siren_drive_next;
  logic                  chime_drive, chime_drive_next;

  logic                  alert_req;
  logic [5:0]            alert_z;
  logic [ZONE_COUNT-1:0] alert_sel;
  logic                  alert_hit;
  logic                  monitor;
  logic                  trip_in_range;

  always_comb begin
    panel_state_next       = panel_state;
    current_mode_next      = current_mode;
    delay_count_next       = delay_count;
    chime_count_next       = chime_count;
    armed_tick_count_next  = armed_tick_count;
    net_offline_count_next = net_offline_count;
    monitor_phase_next     = monitor_phase;
    alert_sent_next        = alert_sent;
    lv_zone_next           = lv_zone;
    lv_kind_next           = lv_kind;
    siren_drive_next       = siren_drive;
    chime_drive_next       = chime_drive;
    alert_req              = 1'b0;
    alert_z                = '0;
    monitor                = 1'b0;
    trip_in_range          = ({3'b000, item.zone_index} < ZONE_LIMIT);

    unique case (item.action)
      apsm_pkg::ACT_TICK: begin
        if (monitor_phase == 4'd0 && item.tamper &&
            (panel_state_next == apsm_pkg::ST_ARMED ||
             panel_state_next == apsm_pkg::ST_ENTRY)) begin
          lv_zone_next      = '0;
          lv_kind_next      = apsm_pkg::KIND_TAMPER;
          panel_state_next  = apsm_pkg::ST_ALARM;
          siren_drive_next  = 1'b1;
        end
        monitor_phase_next = (monitor_phase >= apsm_pkg::TAMPER_LAST) ? 4'd0
                                                                       : monitor_phase + 4'd1;
        if (delay_count_next != 16'd0) begin
          delay_count_next = delay_count_next - 16'd1;
        end
        if (chime_count_next != 8'd0) begin
          chime_count_next = chime_count_next - 8'd1;
          if (chime_count_next == 8'd0) begin
            chime_drive_next = 1'b0;
          end
        end
        if (panel_state_next == apsm_pkg::ST_ARMED ||
            panel_state_next == apsm_pkg::ST_ENTRY) begin
          if (armed_tick_count_next != apsm_pkg::COUNT_MAX) begin
            armed_tick_count_next = armed_tick_count_next + 16'd1;
          end
          if (!item.network_up) begin
            if (net_offline_count_next != apsm_pkg::COUNT_MAX) begin
              net_offline_count_next = net_offline_count_next + 16'd1;
            end
            if (cfg.network_timeout_ticks != 16'd0 &&
                net_offline_count_next == cfg.network_timeout_ticks) begin
              lv_zone_next     = '0;
              lv_kind_next     = apsm_pkg::KIND_NETWORK;
              panel_state_next = apsm_pkg::ST_ALARM;
              siren_drive_next = 1'b1;
            end
          end else begin
            net_offline_count_next = '0;
          end
        end else begin
          armed_tick_count_next  = '0;
          net_offline_count_next = '0;
        end
        if (panel_state_next == apsm_pkg::ST_EXIT && delay_count_next == 16'd0) begin
          panel_state_next = apsm_pkg::ST_ARMED;
        end
        if (panel_state_next == apsm_pkg::ST_ENTRY && delay_count_next == 16'd0) begin
          panel_state_next = apsm_pkg::ST_ALARM;
          siren_drive_next = 1'b1;
          alert_req        = 1'b1;
          alert_z          = lv_zone_next;
        end
      end
      apsm_pkg::ACT_TRIP: begin
        if (item.zone_is_camera) begin
          if (panel_state == apsm_pkg::ST_ARMED || panel_state == apsm_pkg::ST_ENTRY) begin
            panel_state_next = apsm_pkg::ST_ALARM;
            siren_drive_next = 1'b1;
          end
        end else if (trip_in_range) begin
          if (!item.zone_armed_only) begin
            if (item.zone_fire_or_panic) begin
              panel_state_next = apsm_pkg::ST_ALARM;
              siren_drive_next = 1'b1;
              alert_req        = 1'b1;
              alert_z          = item.zone_index;
            end
          end else begin
            if (panel_state == apsm_pkg::ST_DISARMED && item.zone_is_chime &&
                chime_count == 8'd0) begin
              chime_drive_next = 1'b1;
              chime_count_next = cfg.chime_ticks;
            end
            if (panel_state == apsm_pkg::ST_ARMED &&
                !(item.zone_is_interior && armed_tick_count < cfg.grace_ticks)) begin
              case (current_mode)
                apsm_pkg::MODE_STAY:  monitor = item.zone_is_perimeter;
                apsm_pkg::MODE_NIGHT: monitor = item.zone_is_perimeter ||
                                                !item.zone_is_interior;
                default:              monitor = 1'b1;
              endcase
              if (monitor) begin
                lv_zone_next = item.zone_index;
                lv_kind_next = apsm_pkg::KIND_ZONE;
                if (item.zone_is_perimeter) begin
                  panel_state_next = apsm_pkg::ST_ENTRY;
                  delay_count_next = cfg.entry_delay_ticks;
                end else begin
                  panel_state_next = apsm_pkg::ST_ALARM;
                  siren_drive_next = 1'b1;
                  alert_req        = 1'b1;
                  alert_z          = item.zone_index;
                end
              end
            end
          end
        end
      end
      apsm_pkg::ACT_ARM: begin
        if (panel_state == apsm_pkg::ST_DISARMED) begin
          current_mode_next = item.arm_mode;
          panel_state_next  = apsm_pkg::ST_EXIT;
          delay_count_next  = cfg.exit_delay_ticks;
        end
      end
      apsm_pkg::ACT_DISARM: begin
        panel_state_next = apsm_pkg::ST_DISARMED;
        delay_count_next = '0;
        chime_count_next = '0;
        siren_drive_next = 1'b0;
        chime_drive_next = 1'b0;
        alert_sent_next  = '0;
      end
      default: ;
    endcase

    // one-hot zone select, empty for zones beyond the count
    for (int i = 0; i < ZONE_COUNT; i++) begin
      alert_sel[i] = (9'(i) == {3'b000, alert_z});
    end
    alert_hit = alert_req && (|(alert_sel & ~alert_sent));
    if (alert_hit) begin
      lv_zone_next    = alert_z;
      lv_kind_next    = apsm_pkg::KIND_ZONE;
      alert_sent_next = alert_sent | alert_sel;
    end

    result.state_code     = panel_state_next;
    result.armed_mode     = current_mode_next;
    result.timer_left     = delay_count_next;
    result.siren_on       = siren_drive_next;
    result.chime_on       = chime_drive_next;
    result.alert_new      = alert_hit;
    result.alert_zone     = alert_hit ? alert_z : 6'd0;
    result.violation_zone = lv_zone_next;
    result.violation_kind = lv_kind_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      panel_state       <= apsm_pkg::ST_DISARMED;
      current_mode      <= apsm_pkg::MODE_AWAY;
      delay_count       <= '0;
      chime_count       <= '0;
      armed_tick_count  <= '0;
      net_offline_count <= '0;
      monitor_phase     <= '0;
      alert_sent        <= '0;
      lv_zone           <= '0;
      lv_kind           <= apsm_pkg::KIND_NONE;
      siren_drive       <= 1'b0;
      chime_drive       <= 1'b0;
    end else if (step) begin
      panel_state       <= panel_state_next;
      current_mode      <= current_mode_next;
      delay_count       <= delay_count_next;
      chime_count       <= chime_count_next;
      armed_tick_count  <= armed_tick_count_next;
      net_offline_count <= net_offline_count_next;
      monitor_phase     <= monitor_phase_next;
      alert_sent        <= alert_sent_next;
      lv_zone           <= lv_zone_next;
      lv_kind           <= lv_kind_next;
      siren_drive       <= siren_drive_next;
      chime_drive       <= chime_drive_next;
    end
  end

  // siren is only ever raised together with the alarm state
  a_siren_alarm: assert property (@(posedge clk) disable iff (rst)
    siren_drive |-> panel_state == apsm_pkg::ST_ALARM)
    else $error("siren driven outside alarm");

  a_phase_range: assert property (@(posedge clk) disable iff (rst)
    monitor_phase <= apsm_pkg::TAMPER_LAST)
    else $error("tamper phase out of range");

  a_disarm_clears: assert property (@(posedge clk) disable iff (rst)
    step && item.action == apsm_pkg::ACT_DISARM |=>
      alert_sent == '0 && !siren_drive && !chime_drive)
    else $error("disarm left alert or drive state");

endmodule
